FILE: design/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types, register file map and microprogram of the moments merge unit.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 40;
    localparam int MEAN_BITS      = 48;

    // width of the working words: room for d^4 * na * nb * (na^2 - na*nb + nb^2)
    function automatic int wide_bits(input int count_bits);
        return 4 * MEAN_BITS + 3 * count_bits + 40;
    endfunction

    typedef logic [2:0] opc_t;
    localparam opc_t OP_LOAD  = 3'd0;
    localparam opc_t OP_ADD   = 3'd1;
    localparam opc_t OP_SUB   = 3'd2;
    localparam opc_t OP_MUL   = 3'd3;
    localparam opc_t OP_DIV   = 3'd4;
    localparam opc_t OP_STORE = 3'd5;

    localparam int NREG = 32;
    typedef logic [4:0] ridx_t;

    // register file map; a load fills a register from the source of the same name
    localparam ridx_t R_NA   = 5'd0;
    localparam ridx_t R_NB   = 5'd1;
    localparam ridx_t R_MA   = 5'd2;
    localparam ridx_t R_MB   = 5'd3;
    localparam ridx_t R_A2   = 5'd4;
    localparam ridx_t R_B2   = 5'd5;
    localparam ridx_t R_A3   = 5'd6;
    localparam ridx_t R_B3   = 5'd7;
    localparam ridx_t R_A4   = 5'd8;
    localparam ridx_t R_B4   = 5'd9;
    localparam ridx_t R_SC   = 5'd10;
    localparam ridx_t R_K3   = 5'd11;
    localparam ridx_t R_K4   = 5'd12;
    localparam ridx_t R_K6   = 5'd13;
    localparam ridx_t R_N    = 5'd14;
    localparam ridx_t R_D    = 5'd15;
    localparam ridx_t R_D2   = 5'd16;
    localparam ridx_t R_D3   = 5'd17;
    localparam ridx_t R_D4   = 5'd18;
    localparam ridx_t R_P    = 5'd19;
    localparam ridx_t R_NA2  = 5'd20;
    localparam ridx_t R_NB2  = 5'd21;
    localparam ridx_t R_N1   = 5'd22;
    localparam ridx_t R_N2   = 5'd23;
    localparam ridx_t R_N3   = 5'd24;
    localparam ridx_t R_T    = 5'd25;
    localparam ridx_t R_U    = 5'd26;
    localparam ridx_t R_MEAN = 5'd27;
    localparam ridx_t R_M2   = 5'd28;
    localparam ridx_t R_M3   = 5'd29;
    localparam ridx_t R_M4   = 5'd30;

    typedef struct packed {
        opc_t  opc;
        ridx_t dst;
        ridx_t srca;
        ridx_t srcb;
    } uop_t;

    localparam int PROG_LEN = 72;
    typedef logic [6:0] pc_t;

    typedef struct packed {
        logic capture;
        logic rd;
        logic start;
        logic publish;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_stat_t;

    function automatic uop_t mk(input opc_t o, input ridx_t d, input ridx_t a,
                                input ridx_t b);
        uop_t u;
        u.opc  = o;
        u.dst  = d;
        u.srca = a;
        u.srcb = b;
        return u;
    endfunction

    // the merge program; the second source of a multiply is the narrow one
    function automatic uop_t prog(input pc_t pc);
        uop_t u;
        unique case (pc)
            7'd14: u = mk(OP_ADD, R_N, R_NA, R_NB);
            7'd15: u = mk(OP_SUB, R_D, R_MB, R_MA);
            7'd16: u = mk(OP_MUL, R_D2, R_D, R_D);
            7'd17: u = mk(OP_MUL, R_D3, R_D2, R_D);
            7'd18: u = mk(OP_MUL, R_D4, R_D2, R_D2);
            7'd19: u = mk(OP_MUL, R_P, R_NB, R_NA);
            7'd20: u = mk(OP_MUL, R_NA2, R_NA, R_NA);
            7'd21: u = mk(OP_MUL, R_NB2, R_NB, R_NB);
            7'd22: u = mk(OP_MUL, R_N1, R_N, R_SC);
            7'd23: u = mk(OP_MUL, R_N2, R_N1, R_N1);
            7'd24: u = mk(OP_MUL, R_N3, R_N2, R_N1);
            7'd25: u = mk(OP_MUL, R_T, R_MA, R_NA);
            7'd26: u = mk(OP_MUL, R_U, R_MB, R_NB);
            7'd27: u = mk(OP_ADD, R_T, R_T, R_U);
            7'd28: u = mk(OP_DIV, R_MEAN, R_T, R_N);
            7'd29: u = mk(OP_MUL, R_T, R_D2, R_P);
            7'd30: u = mk(OP_DIV, R_T, R_T, R_N1);
            7'd31: u = mk(OP_ADD, R_M2, R_A2, R_B2);
            7'd32: u = mk(OP_ADD, R_M2, R_M2, R_T);
            7'd33: u = mk(OP_ADD, R_M3, R_A3, R_B3);
            7'd34: u = mk(OP_MUL, R_T, R_D3, R_P);
            7'd35: u = mk(OP_SUB, R_U, R_NA, R_NB);
            7'd36: u = mk(OP_MUL, R_T, R_T, R_U);
            7'd37: u = mk(OP_DIV, R_T, R_T, R_N2);
            7'd38: u = mk(OP_ADD, R_M3, R_M3, R_T);
            7'd39: u = mk(OP_MUL, R_T, R_B2, R_NA);
            7'd40: u = mk(OP_MUL, R_U, R_A2, R_NB);
            7'd41: u = mk(OP_SUB, R_T, R_T, R_U);
            7'd42: u = mk(OP_MUL, R_U, R_D, R_K3);
            7'd43: u = mk(OP_MUL, R_T, R_T, R_U);
            7'd44: u = mk(OP_DIV, R_T, R_T, R_N1);
            7'd45: u = mk(OP_ADD, R_M3, R_M3, R_T);
            7'd46: u = mk(OP_ADD, R_M4, R_A4, R_B4);
            7'd47: u = mk(OP_SUB, R_T, R_NA2, R_P);
            7'd48: u = mk(OP_ADD, R_T, R_T, R_NB2);
            7'd49: u = mk(OP_MUL, R_U, R_D4, R_P);
            7'd50: u = mk(OP_MUL, R_T, R_U, R_T);
            7'd51: u = mk(OP_DIV, R_T, R_T, R_N3);
            7'd52: u = mk(OP_ADD, R_M4, R_M4, R_T);
            7'd53: u = mk(OP_MUL, R_T, R_B2, R_NA2);
            7'd54: u = mk(OP_MUL, R_U, R_A2, R_NB2);
            7'd55: u = mk(OP_ADD, R_T, R_T, R_U);
            7'd56: u = mk(OP_MUL, R_U, R_D2, R_K6);
            7'd57: u = mk(OP_MUL, R_T, R_T, R_U);
            7'd58: u = mk(OP_DIV, R_T, R_T, R_N2);
            7'd59: u = mk(OP_ADD, R_M4, R_M4, R_T);
            7'd60: u = mk(OP_MUL, R_T, R_B3, R_NA);
            7'd61: u = mk(OP_MUL, R_U, R_A3, R_NB);
            7'd62: u = mk(OP_SUB, R_T, R_T, R_U);
            7'd63: u = mk(OP_MUL, R_U, R_D, R_K4);
            7'd64: u = mk(OP_MUL, R_T, R_T, R_U);
            7'd65: u = mk(OP_DIV, R_T, R_T, R_N1);
            7'd66: u = mk(OP_ADD, R_M4, R_M4, R_T);
            7'd67: u = mk(OP_STORE, R_N, R_N, R_N);
            7'd68: u = mk(OP_STORE, R_MEAN, R_MEAN, R_MEAN);
            7'd69: u = mk(OP_STORE, R_M2, R_M2, R_M2);
            7'd70: u = mk(OP_STORE, R_M3, R_M3, R_M3);
            7'd71: u = mk(OP_STORE, R_M4, R_M4, R_M4);
            // operand loads at the head of the program
            default: u = mk(OP_LOAD, pc[4:0], pc[4:0], pc[4:0]);
        endcase
        return u;
    endfunction

endpackage

FILE: design/cmm_datapath.sv
// ----------------------------------------------------------------------------
// cmm_datapath
// Register file, shift-add multiplier, restoring divider, saturation and the
// running and output registers of the moments merge unit.
// ----------------------------------------------------------------------------
module cmm_datapath
    import cmm_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [31:0]           part_count,
    input  logic [47:0]           part_mean,
    input  logic [62:0]           part_m2,
    input  logic [63:0]           part_m3,
    input  logic [62:0]           part_m4,
    output logic [COUNT_BITS-1:0] total_count,
    output logic [47:0]           total_mean,
    output logic [62:0]           total_m2,
    output logic [63:0]           total_m3,
    output logic [62:0]           total_m4,
    output logic                  overflow
);

    localparam int WB = wide_bits(COUNT_BITS);
    localparam int CW = $clog2(WB + 1);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    typedef logic [WB-1:0] word_t;

    word_t rf [NREG];
    word_t a_reg, b_reg;

    logic [31:0] in_cnt_reg;
    logic [47:0] in_mean_reg;
    logic [62:0] in_m2_reg;
    logic [63:0] in_m3_reg;
    logic [62:0] in_m4_reg;

    logic [COUNT_BITS-1:0] run_cnt_reg;
    logic [47:0]           run_mean_reg;
    logic [62:0]           run_m2_reg;
    logic [63:0]           run_m3_reg;
    logic [62:0]           run_m4_reg;
    logic                  sat_reg;
    logic                  nz_reg;

    logic [COUNT_BITS-1:0] out_cnt_reg;
    logic [47:0]           out_mean_reg;
    logic [62:0]           out_m2_reg;
    logic [63:0]           out_m3_reg;
    logic [62:0]           out_m4_reg;
    logic                  out_ovf_reg;

    logic [1:0]  mode_reg;
    ridx_t       dst_reg;
    logic        sgn_reg;
    word_t       acc_reg, mcand_reg, mplier_reg;
    word_t       num_reg, rem_reg, den_reg;
    logic [CW-1:0] cnt_reg;

    word_t         abs_a, abs_b, load_val, wd, mul_sum;
    logic [WB:0]   rem2, diff;
    logic          qbit, mul_fin, div_fin, we;
    ridx_t         wa;

    logic [COUNT_BITS-1:0] st_cnt;
    logic [47:0]           st_mean;
    logic [62:0]           st_m2, st_m4;
    logic [63:0]           st_m3;
    logic                  ov_cnt, ov_mean, ov_m2, ov_m3, ov_m4;
    logic                  mean_fit, m3_fit, u63_big;

    assign abs_a = a_reg[WB-1] ? (~a_reg + word_t'(1)) : a_reg;
    assign abs_b = b_reg[WB-1] ? (~b_reg + word_t'(1)) : b_reg;

    always_comb
    begin
        unique case (cmd.uop.dst)
            R_NA:    load_val = word_t'(in_cnt_reg);
            R_NB:    load_val = word_t'(run_cnt_reg);
            R_MA:    load_val = {{(WB-48){in_mean_reg[47]}}, in_mean_reg};
            R_MB:    load_val = {{(WB-48){run_mean_reg[47]}}, run_mean_reg};
            R_A2:    load_val = word_t'(in_m2_reg);
            R_B2:    load_val = word_t'(run_m2_reg);
            R_A3:    load_val = {{(WB-64){in_m3_reg[63]}}, in_m3_reg};
            R_B3:    load_val = {{(WB-64){run_m3_reg[63]}}, run_m3_reg};
            R_A4:    load_val = word_t'(in_m4_reg);
            R_B4:    load_val = word_t'(run_m4_reg);
            R_SC:    load_val = word_t'(1) << FRAC_BITS;
            R_K3:    load_val = word_t'(3);
            R_K4:    load_val = word_t'(4);
            R_K6:    load_val = word_t'(6);
            default: load_val = '0;
        endcase
    end

    // one shift-add step and one restoring divide step
    assign mul_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem2    = {rem_reg, num_reg[WB-1]};
    assign diff    = rem2 - {1'b0, den_reg};
    assign qbit    = ~diff[WB];

    assign mul_fin = (mode_reg == M_MUL) && (mplier_reg == '0);
    assign div_fin = (mode_reg == M_DIV) && (cnt_reg == '0);
    assign stat.done = mul_fin | div_fin;

    always_comb
    begin
        we = 1'b0;
        wa = dst_reg;
        wd = '0;
        if (mul_fin)
        begin
            we = 1'b1;
            wd = sgn_reg ? (~acc_reg + word_t'(1)) : acc_reg;
        end
        else if (div_fin)
        begin
            we = 1'b1;
            wd = sgn_reg ? (~num_reg + word_t'(1)) : num_reg;
        end
        else if (cmd.start)
        begin
            wa = cmd.uop.dst;
            priority case (cmd.uop.opc)
                OP_LOAD:
                begin
                    we = 1'b1;
                    wd = load_val;
                end
                OP_ADD:
                begin
                    we = 1'b1;
                    wd = a_reg + b_reg;
                end
                OP_SUB:
                begin
                    we = 1'b1;
                    wd = a_reg - b_reg;
                end
                default: we = 1'b0;
            endcase
        end
    end

    // saturation of the merged values
    assign mean_fit = (a_reg[WB-1:MEAN_BITS-1] == '0) || (a_reg[WB-1:MEAN_BITS-1] == '1);
    assign m3_fit   = (a_reg[WB-1:63] == '0) || (a_reg[WB-1:63] == '1);
    assign u63_big  = |a_reg[WB-2:63];

    always_comb
    begin
        ov_cnt = |a_reg[WB-1:COUNT_BITS];
        st_cnt = ov_cnt ? '1 : a_reg[COUNT_BITS-1:0];

        ov_mean = nz_reg && !mean_fit;
        if (!nz_reg)
            st_mean = '0;
        else if (mean_fit)
            st_mean = a_reg[47:0];
        else
            st_mean = a_reg[WB-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};

        ov_m3 = nz_reg && !m3_fit;
        if (!nz_reg)
            st_m3 = '0;
        else if (m3_fit)
            st_m3 = a_reg[63:0];
        else
            st_m3 = a_reg[WB-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};

        ov_m2 = nz_reg && (a_reg[WB-1] || u63_big);
        if (!nz_reg || a_reg[WB-1])
            st_m2 = '0;
        else if (u63_big)
            st_m2 = '1;
        else
            st_m2 = a_reg[62:0];

        ov_m4 = ov_m2;
        st_m4 = st_m2;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            rf[wa] <= wd;
        if (cmd.rd)
        begin
            a_reg <= rf[cmd.uop.srca];
            b_reg <= rf[cmd.uop.srcb];
        end
        if (cmd.capture)
        begin
            in_cnt_reg  <= part_count;
            in_mean_reg <= part_mean;
            in_m2_reg   <= part_m2;
            in_m3_reg   <= part_m3;
            in_m4_reg   <= part_m4;
        end
        if (cmd.publish)
        begin
            out_cnt_reg  <= run_cnt_reg;
            out_mean_reg <= run_mean_reg;
            out_m2_reg   <= run_m2_reg;
            out_m3_reg   <= run_m3_reg;
            out_m4_reg   <= run_m4_reg;
            out_ovf_reg  <= sat_reg;
        end
    end

    // iterative multiply and divide
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dst_reg <= cmd.uop.dst;
            if (cmd.uop.opc == OP_MUL)
            begin
                sgn_reg    <= a_reg[WB-1] ^ b_reg[WB-1];
                acc_reg    <= '0;
                mcand_reg  <= abs_a;
                mplier_reg <= abs_b;
            end
            else
            begin
                sgn_reg <= a_reg[WB-1];
                num_reg <= abs_a;
                den_reg <= b_reg;
                rem_reg <= '0;
                cnt_reg <= CW'(WB);
            end
        end
        else if (mode_reg == M_MUL && !mul_fin)
        begin
            acc_reg    <= mul_sum;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        else if (mode_reg == M_DIV && !div_fin)
        begin
            rem_reg <= qbit ? diff[WB-1:0] : rem2[WB-1:0];
            num_reg <= {num_reg[WB-2:0], qbit};
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            run_cnt_reg  <= '0;
            run_mean_reg <= '0;
            run_m2_reg   <= '0;
            run_m3_reg   <= '0;
            run_m4_reg   <= '0;
            sat_reg      <= 1'b0;
            nz_reg       <= 1'b0;
        end
        else
        begin
            if (mul_fin || div_fin)
                mode_reg <= M_IDLE;
            else if (cmd.start && cmd.uop.opc == OP_MUL)
                mode_reg <= M_MUL;
            else if (cmd.start && cmd.uop.opc == OP_DIV)
                mode_reg <= M_DIV;

            if (cmd.start && cmd.uop.opc == OP_STORE)
            begin
                priority case (cmd.uop.srca)
                    R_N:
                    begin
                        run_cnt_reg <= st_cnt;
                        nz_reg      <= |a_reg;
                        sat_reg     <= sat_reg | ov_cnt;
                    end
                    R_MEAN:
                    begin
                        run_mean_reg <= st_mean;
                        sat_reg      <= sat_reg | ov_mean;
                    end
                    R_M2:
                    begin
                        run_m2_reg <= st_m2;
                        sat_reg    <= sat_reg | ov_m2;
                    end
                    R_M3:
                    begin
                        run_m3_reg <= st_m3;
                        sat_reg    <= sat_reg | ov_m3;
                    end
                    R_M4:
                    begin
                        run_m4_reg <= st_m4;
                        sat_reg    <= sat_reg | ov_m4;
                    end
                    default: sat_reg <= sat_reg;
                endcase
            end
        end
    end

    assign total_count = out_cnt_reg;
    assign total_mean  = out_mean_reg;
    assign total_m2    = out_m2_reg;
    assign total_m3    = out_m3_reg;
    assign total_m4    = out_m4_reg;
    assign overflow    = out_ovf_reg;

endmodule

FILE: design/cmm_ctrl.sv
// ----------------------------------------------------------------------------
// cmm_ctrl
// Sequencer: takes a request, steps the datapath through the merge program
// and hands the merged set to the output register.
// ----------------------------------------------------------------------------
module cmm_ctrl
    import cmm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_PUB  = 3'd4;

    logic [2:0] state_reg, state_next;
    pc_t        pc_reg, pc_next;
    logic       out_valid_reg, out_valid_next;
    uop_t       uop;
    logic       last, multi;

    assign uop   = prog(pc_reg);
    assign last  = (pc_reg == pc_t'(PROG_LEN - 1));
    assign multi = (uop.opc == OP_MUL) || (uop.opc == OP_DIV);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.rd      = (state_reg == S_READ);
        cmd.start   = (state_reg == S_EXEC);
        cmd.publish = (state_reg == S_PUB) && (!out_valid_reg || out_ready);
        cmd.uop     = uop;
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pc_next    = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_EXEC;
            S_EXEC, S_WAIT:
            begin
                if ((state_reg == S_EXEC && !multi) || (state_reg == S_WAIT && stat.done))
                begin
                    if (last)
                        state_next = S_PUB;
                    else
                    begin
                        pc_next    = pc_reg + pc_t'(1);
                        state_next = S_READ;
                    end
                end
                else if (state_reg == S_EXEC)
                    state_next = S_WAIT;
            end
            S_PUB:
            begin
                if (cmd.publish)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/central_moments_merge.sv
// ----------------------------------------------------------------------------
// central_moments_merge
// Running merge of partial statistics (count, mean, second to fourth central
// moment sums) into a stored total, fixed point with FRAC_BITS fraction bits.
//
// Usage: a request on the input channel (in_valid / in_ready) carries one
// partial set. It is merged with the running set, the running set is updated
// and the merged set is offered on the output channel (out_valid / out_ready)
// with a sticky overflow flag. One request is worked on at a time; in_ready
// is high while the sequencer is idle, also while a result still waits.
// Each request runs the merge program of 72 steps, among them 7 divisions on
// the bit-serial divider and 28 shift-add multiplies, which end when no
// significant multiplier bit is left.
// A stalled receiver holds the result in the output register; the next
// request is taken and computed, then waits until the old result is taken.
// Reset clears the running set, the sticky flag and the output valid flag.
// ----------------------------------------------------------------------------
module central_moments_merge
    import cmm_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           part_count,
    input  logic [47:0]           part_mean,
    input  logic [62:0]           part_m2,
    input  logic [63:0]           part_m3,
    input  logic [62:0]           part_m4,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COUNT_BITS-1:0] total_count,
    output logic [47:0]           total_mean,
    output logic [62:0]           total_m2,
    output logic [63:0]           total_m3,
    output logic [62:0]           total_m4,
    output logic                  overflow
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cmm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    cmm_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .part_count  (part_count),
        .part_mean   (part_mean),
        .part_m2     (part_m2),
        .part_m3     (part_m3),
        .part_m4     (part_m4),
        .total_count (total_count),
        .total_mean  (total_mean),
        .total_m2    (total_m2),
        .total_m3    (total_m3),
        .total_m4    (total_m4),
        .overflow    (overflow)
    );

endmodule
